[design/cccv_pkg.sv]
// Shared types, constants and helpers for the CC/CV charger duty controller.
`timescale 1ns / 1ps

package cccv_pkg;

    // Field widths
    localparam int CUR_W   = 19;
    localparam int VOLT_W  = 14;
    localparam int SOC_W   = 10;
    localparam int DUTY_W  = 14;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Duty scale: 10000 counts = 1.0
    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(10000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_HIGH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOC_RESUME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_DUTY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_DUTY = 3'd4;

    // Register reset values
    localparam logic [SOC_W-1:0]  SOC_LOW_RST        = SOC_W'(800);
    localparam logic [SOC_W-1:0]  SOC_HIGH_RST       = SOC_W'(950);
    localparam logic [SOC_W-1:0]  SOC_RESUME_RST     = SOC_W'(990);
    localparam logic [DUTY_W-1:0] RESTART_DUTY_RST   = DUTY_W'(6400);
    localparam logic [DUTY_W-1:0] DISCHARGE_DUTY_RST = DUTY_W'(3480);

    // Current bands, 10 uA units
    localparam logic signed [CUR_W-1:0] CUR_ZERO_LIM  = 19'sd1;
    localparam logic signed [CUR_W-1:0] CUR_DN_BIG    = 19'sd30000;
    localparam logic signed [CUR_W-1:0] CUR_DN_MID    = 19'sd60000;
    localparam logic signed [CUR_W-1:0] CUR_DN_FINE   = 19'sd85000;
    localparam logic signed [CUR_W-1:0] CUR_UP_BIG    = 19'sd135000;
    localparam logic signed [CUR_W-1:0] CUR_UP_MID    = 19'sd125000;
    localparam logic signed [CUR_W-1:0] CUR_UP_FINE   = 19'sd115000;

    // Voltage bands, mV
    localparam logic signed [VOLT_W-1:0] VOLT_UP_MID   = 14'sd4000;
    localparam logic signed [VOLT_W-1:0] VOLT_UP_FINE  = 14'sd4100;
    localparam logic signed [VOLT_W-1:0] VOLT_DN_MID   = 14'sd4500;
    localparam logic signed [VOLT_W-1:0] VOLT_DN_FINE  = 14'sd4300;
    localparam logic signed [VOLT_W-1:0] VOLT_DIS_MIN  = 14'sd3000;

    // Duty steps
    localparam logic signed [7:0] STEP_BIG  = 8'sd100;
    localparam logic signed [7:0] STEP_MID  = 8'sd10;
    localparam logic signed [7:0] STEP_FINE = 8'sd1;
    localparam logic signed [7:0] STEP_NONE = 8'sd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_CC        = 2'd0,
        MODE_CV        = 2'd1,
        MODE_CHARGED   = 2'd2,
        MODE_DISCHARGE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [SOC_W-1:0]  soc_low;
        logic [SOC_W-1:0]  soc_high;
        logic [SOC_W-1:0]  soc_resume;
        logic [DUTY_W-1:0] restart_duty;
        logic [DUTY_W-1:0] discharge_duty;
    } cfg_t;

    typedef struct packed {
        logic signed [CUR_W-1:0]  out_current;
        logic signed [VOLT_W-1:0] out_voltage;
        logic [SOC_W-1:0]         charge_level;
        logic                     discharge_request;
    } item_t;

    // Clamp a signed duty to 0..DUTY_MAX
    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [15:0] d);
        logic [DUTY_W-1:0] r;
        if (d < 16'sd0) begin
            r = '0;
        end else if (d > $signed({2'b00, DUTY_MAX})) begin
            r = DUTY_MAX;
        end else begin
            r = d[DUTY_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/cccv_cfg_regs.sv]
// Configuration register bank for the charger duty controller.
`timescale 1ns / 1ps

module cccv_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cccv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cccv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output cccv_pkg::cfg_t                    cfg
);

    cccv_pkg::cfg_t cfg_reg;
    cccv_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                cccv_pkg::CFG_SOC_LOW: begin
                    cfg_next.soc_low = cfg_wdata[cccv_pkg::SOC_W-1:0];
                end
                cccv_pkg::CFG_SOC_HIGH: begin
                    cfg_next.soc_high = cfg_wdata[cccv_pkg::SOC_W-1:0];
                end
                cccv_pkg::CFG_SOC_RESUME: begin
                    cfg_next.soc_resume = cfg_wdata[cccv_pkg::SOC_W-1:0];
                end
                cccv_pkg::CFG_RESTART_DUTY: begin
                    cfg_next.restart_duty = cfg_wdata[cccv_pkg::DUTY_W-1:0];
                end
                cccv_pkg::CFG_DISCHARGE_DUTY: begin
                    cfg_next.discharge_duty = cfg_wdata[cccv_pkg::DUTY_W-1:0];
                end
                default: begin
                    // unused index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.soc_low        <= cccv_pkg::SOC_LOW_RST;
            cfg_reg.soc_high       <= cccv_pkg::SOC_HIGH_RST;
            cfg_reg.soc_resume     <= cccv_pkg::SOC_RESUME_RST;
            cfg_reg.restart_duty   <= cccv_pkg::RESTART_DUTY_RST;
            cfg_reg.discharge_duty <= cccv_pkg::DISCHARGE_DUTY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/cccv_step.sv]
// Next mode and duty for one measurement: band ladder, one add, clamp.
`timescale 1ns / 1ps

module cccv_step (
    input  cccv_pkg::cfg_t                  cfg,
    input  cccv_pkg::item_t                 item,
    input  cccv_pkg::mode_t                 mode_cur,
    input  logic [cccv_pkg::DUTY_W-1:0]     duty_cur,
    output cccv_pkg::mode_t                 mode_nxt,
    output logic [cccv_pkg::DUTY_W-1:0]     duty_nxt
);

    logic signed [7:0]  cc_step;
    logic signed [7:0]  cv_step;
    logic signed [7:0]  step;
    logic signed [15:0] duty_sum;
    logic [cccv_pkg::DUTY_W-1:0] restart_sat;
    logic [cccv_pkg::DUTY_W-1:0] discharge_sat;
    logic volt_pos;

    // Current ladder (first match wins)
    always_comb begin
        if (item.out_current <= cccv_pkg::CUR_DN_BIG) begin
            cc_step = -cccv_pkg::STEP_BIG;
        end else if (item.out_current <= cccv_pkg::CUR_DN_MID) begin
            cc_step = -cccv_pkg::STEP_MID;
        end else if (item.out_current <= cccv_pkg::CUR_DN_FINE) begin
            cc_step = -cccv_pkg::STEP_FINE;
        end else if (item.out_current >= cccv_pkg::CUR_UP_BIG) begin
            cc_step = cccv_pkg::STEP_BIG;
        end else if (item.out_current >= cccv_pkg::CUR_UP_MID) begin
            cc_step = cccv_pkg::STEP_MID;
        end else if (item.out_current >= cccv_pkg::CUR_UP_FINE) begin
            cc_step = cccv_pkg::STEP_FINE;
        end else begin
            cc_step = cccv_pkg::STEP_NONE;
        end
    end

    // Voltage ladder; negative readings leave the duty alone
    assign volt_pos = !item.out_voltage[cccv_pkg::VOLT_W-1];

    always_comb begin
        if (volt_pos && item.out_voltage <= cccv_pkg::VOLT_UP_MID) begin
            cv_step = cccv_pkg::STEP_MID;
        end else if (volt_pos && item.out_voltage <= cccv_pkg::VOLT_UP_FINE) begin
            cv_step = cccv_pkg::STEP_FINE;
        end else if (item.out_voltage >= cccv_pkg::VOLT_DN_MID) begin
            cv_step = -cccv_pkg::STEP_MID;
        end else if (item.out_voltage >= cccv_pkg::VOLT_DN_FINE) begin
            cv_step = -cccv_pkg::STEP_FINE;
        end else begin
            cv_step = cccv_pkg::STEP_NONE;
        end
    end

    assign step = (mode_cur == cccv_pkg::MODE_CC) ? cc_step : cv_step;
    assign duty_sum = $signed({2'b00, duty_cur}) + $signed({{8{step[7]}}, step});

    assign restart_sat   = cccv_pkg::sat_duty($signed({2'b00, cfg.restart_duty}));
    assign discharge_sat = cccv_pkg::sat_duty($signed({2'b00, cfg.discharge_duty}));

    always_comb begin
        mode_nxt = mode_cur;
        duty_nxt = duty_cur;
        case (mode_cur)
            cccv_pkg::MODE_CC: begin
                if (item.out_current < cccv_pkg::CUR_ZERO_LIM) begin
                    duty_nxt = restart_sat;
                end else begin
                    duty_nxt = cccv_pkg::sat_duty(duty_sum);
                end
                if (item.charge_level >= cfg.soc_low) begin
                    mode_nxt = cccv_pkg::MODE_CV;
                end
            end
            cccv_pkg::MODE_CV: begin
                duty_nxt = cccv_pkg::sat_duty(duty_sum);
                if (item.charge_level >= cfg.soc_high) begin
                    mode_nxt = cccv_pkg::MODE_CHARGED;
                end
            end
            cccv_pkg::MODE_CHARGED: begin
                if (item.discharge_request) begin
                    mode_nxt = cccv_pkg::MODE_DISCHARGE;
                end else if (item.charge_level < cfg.soc_low) begin
                    mode_nxt = cccv_pkg::MODE_CC;
                end else if (item.charge_level < cfg.soc_resume) begin
                    mode_nxt = cccv_pkg::MODE_CV;
                end
            end
            default: begin
                duty_nxt = discharge_sat;
                if (!item.discharge_request || item.out_voltage < cccv_pkg::VOLT_DIS_MIN) begin
                    mode_nxt = cccv_pkg::MODE_CC;
                end
            end
        endcase
    end

endmodule

[design/cc_cv_charger_duty_controller_top.sv]
// Top level of the CC/CV charger duty controller: handshakes, state and result register.
`timescale 1ns / 1ps

// Usage
//   Slave stream s_*: one measurement request per handshake. s_tdata carries
//   out_current, out_voltage and charge_level; s_tuser carries discharge_request.
//   Master stream m_*: one result per request, duty_out and mode_out in m_tdata.
//   cfg_*: write-only register port, index 0..4 = soc_low, soc_high, soc_resume,
//   restart_duty, discharge_duty; other indexes ignored. Write only when idle.
// Timing
//   A request is captured in the input register; when the result slot is free or being
//   drained, the mode ladder and duty add run on it and load the result register,
//   which is also the charger state and drives m_tvalid.
//   Throughput: one request per cycle while m_tready stays high, set by the single
//   add-and-clamp path between the input register and the state/result register.
// Reset (aresetn low, synchronous)
//   Registers go to their defaults, mode to constant current, duty to zero,
//   both stages empty.
// Stall
//   While m_tready is low the result holds; one more request waits in the
//   input register, after which s_tready drops until the result is taken.

module cc_cv_charger_duty_controller_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // [18:0] out_current, [32:19] out_voltage,
                                                       // [42:33] charge_level, [47:43] zero
    input  logic [0:0]                       s_tuser,  // [0] discharge_request
    // master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,  // [13:0] duty_out, [15:14] mode_out
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [cccv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cccv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    cccv_pkg::cfg_t   cfg;
    cccv_pkg::item_t  in_item_reg;
    cccv_pkg::item_t  in_item_next;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    cccv_pkg::mode_t  mode_reg;
    cccv_pkg::mode_t  mode_next;
    logic [cccv_pkg::DUTY_W-1:0] duty_reg;
    logic [cccv_pkg::DUTY_W-1:0] duty_next;
    cccv_pkg::mode_t  step_mode;
    logic [cccv_pkg::DUTY_W-1:0] step_duty;
    logic             in_take;
    logic             advance;

    cccv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cccv_step u_step (
        .cfg      (cfg),
        .item     (in_item_reg),
        .mode_cur (mode_reg),
        .duty_cur (duty_reg),
        .mode_nxt (step_mode),
        .duty_nxt (step_duty)
    );

    // Request moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_item_next = in_item_reg;
        if (in_take) begin
            in_item_next.out_current       = $signed(s_tdata[18:0]);
            in_item_next.out_voltage       = $signed(s_tdata[32:19]);
            in_item_next.charge_level      = s_tdata[42:33];
            in_item_next.discharge_request = s_tuser[0];
        end
    end

    always_comb begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        mode_next      = advance ? step_mode : mode_reg;
        duty_next      = advance ? step_duty : duty_reg;
    end

    // payload
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    // control and charger state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= cccv_pkg::MODE_CC;
            duty_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            duty_reg      <= duty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {mode_reg, duty_reg};

    // Assertions
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (mode_reg == cccv_pkg::MODE_CC) && (duty_reg == '0) && !m_tvalid)
        else $error("charger state not cleared by reset");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg <= cccv_pkg::DUTY_MAX)
        else $error("duty above full scale");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(duty_reg) && $stable(mode_reg))
        else $error("charger state changed without a request");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending request lost");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result not presented after step");

endmodule
